### hdl/four_voice_synth_mixer_top_defines.svh
// ---------------------------------------------------------------------------
// Four-voice synth mixer: assertion macros
// Shared property wrappers for the mixer's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef FOUR_VOICE_SYNTH_MIXER_TOP_DEFINES_SVH
`define FOUR_VOICE_SYNTH_MIXER_TOP_DEFINES_SVH

// check sampled on clk_i, ignored while rst_ni is low
`define FVSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check sampled on clk_i that must also hold through reset
`define FVSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/fvsm_pkg.sv
// ---------------------------------------------------------------------------
// Four-voice synth mixer package
// Request codes, waveform and envelope encodings, constants and helpers.
// ---------------------------------------------------------------------------
package fvsm_pkg;

  // default voice count
  localparam int VoicesDef = 4;

  localparam logic [15:0] LfsrTaps  = 16'hB400;
  localparam logic [15:0] LfsrSeed  = 16'hACE1;
  localparam logic [14:0] AmpPeak   = 15'h7FFF;
  localparam logic [15:0] NoiseDrop = 16'd16384;
  localparam int          CfgIdxW   = 3;

  // request codes
  typedef enum logic [2:0] {
    REQ_SAMPLE    = 3'd0,
    REQ_ENV_TICK  = 3'd1,
    REQ_NOTE_ON   = 3'd2,
    REQ_NOTE_OFF  = 3'd3,
    REQ_RESET_ALL = 3'd4
  } req_e;

  // waveform select
  typedef enum logic [1:0] {
    SHAPE_TRI   = 2'd0,
    SHAPE_PULSE = 2'd1,
    SHAPE_SAW   = 2'd2,
    SHAPE_NOISE = 2'd3
  } shape_e;

  // envelope stage
  typedef enum logic [1:0] {
    ST_RELEASE = 2'd0,
    ST_ATTACK  = 2'd1,
    ST_DECAY   = 2'd2,
    ST_HOLD    = 2'd3
  } stage_e;

  // packed envelope register, MSB first
  typedef struct packed {
    logic [7:0] rel;
    logic [6:0] sus;
    logic [7:0] dec;
    logic [7:0] atk;
  } env_cfg_t;

  // one Galois step: shift right, fold taps in if a one falls out
  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    logic [15:0] r;
    r = {1'b0, s[15:1]};
    if (s[0]) r = r ^ LfsrTaps;
    return r;
  endfunction

endpackage

### hdl/four_voice_synth_mixer_top.sv
// ---------------------------------------------------------------------------
// Four-voice synth mixer
// Tone generators with envelopes, mixed to one unsigned 8-bit sample.
// ---------------------------------------------------------------------------
// Usage:
//   Request words arrive on the in_* channel (valid/ready). A sample tick
//   advances every voice and yields one word on the out_* channel; envelope
//   ticks, note on/off and reset-all update voice state and yield nothing.
//   Envelope settings are written on the cfg_* channel, one register per
//   voice; write them only while the block is idle. cfg_ready_o is always
//   high and writes at an index beyond the voice count are dropped.
// Timing:
//   An accepted word sits in the input register, where the single processing
//   stage updates state and loads the result register; out_valid_o rises
//   when the result register takes the sample. One word per cycle is
//   sustained while sample ticks are not held back by out_ready_i; the
//   processing stage is the only datapath step.
// Reset:
//   All voices are silent with zero phase, the LFSR is reseeded, envelope
//   registers read zero and both pipeline registers are empty.
// Stalls:
//   While out_ready_i is low a held sample blocks only the next sample
//   tick; other requests keep flowing, and in_ready_o drops when a sample
//   tick cannot retire.
// ---------------------------------------------------------------------------
`include "four_voice_synth_mixer_top_defines.svh"

module four_voice_synth_mixer_top
  import fvsm_pkg::*;
#(
  parameter int VOICES = VoicesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         req_type_i,
  input  logic [1:0]         voice_i,
  input  logic [15:0]        tone_step_i,
  input  logic [1:0]         wave_shape_i,
  input  logic [7:0]         pulse_width_i,
  // sample channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         sample_o,
  // configuration channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [30:0]        cfg_data_i
);

  // input register
  logic        s1_valid_q, s1_valid_d;
  logic [2:0]  req_q;
  logic [1:0]  voice_q;
  logic [15:0] tone_step_q;
  logic [1:0]  wave_shape_q;
  logic [7:0]  pulse_width_q;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [7:0]  sample_q, sample_d;

  // voice state
  env_cfg_t    env_cfg_q   [VOICES];
  logic [15:0] phase_q     [VOICES];
  logic [15:0] phase_d     [VOICES];
  logic [15:0] step_q      [VOICES];
  logic [15:0] step_d      [VOICES];
  shape_e      shape_q     [VOICES];
  shape_e      shape_d     [VOICES];
  logic [7:0]  width_q     [VOICES];
  logic [7:0]  width_d     [VOICES];
  logic [14:0] amp_q       [VOICES];
  logic [14:0] amp_d       [VOICES];
  stage_e      stage_q     [VOICES];
  stage_e      stage_d     [VOICES];
  logic [7:0]  noise_q     [VOICES];
  logic [7:0]  noise_d     [VOICES];
  logic [15:0] lfsr_q, lfsr_d;

  // sample tick results
  logic [15:0]        smp_phase [VOICES];
  logic [7:0]         smp_noise [VOICES];
  logic signed [15:0] prod      [VOICES];
  logic signed [17:0] sum_s;
  logic [15:0]        smp_lfsr;
  logic [7:0]         smp_out;

  // envelope tick results
  logic [14:0] env_amp   [VOICES];
  stage_e      env_stage [VOICES];

  logic in_fire, out_free, s1_is_sample, s1_adv;

  // handshake
  assign out_free     = !out_valid_q || out_ready_i;
  assign s1_is_sample = (req_q == REQ_SAMPLE);
  assign s1_adv       = s1_valid_q && (!s1_is_sample || out_free);
  assign in_ready_o   = !s1_valid_q || s1_adv;
  assign in_fire      = in_valid_i && in_ready_o;
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign sample_o     = sample_q;

  assign s1_valid_d = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  // result register next value
  always_comb begin
    out_valid_d = out_valid_q;
    sample_d    = sample_q;
    if (s1_adv && s1_is_sample) begin
      out_valid_d = 1'b1;
      sample_d    = smp_out;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // sample tick: oscillators, noise chain, scaling and mix
  always_comb begin : p_mix
    logic [15:0]        chain;
    logic [15:0]        nxt;
    logic [15:0]        ph;
    logic [7:0]         p;
    logic [7:0]         nl;
    logic signed [7:0]  wv;
    logic [17:0]        shifted;
    chain = lfsr_q;
    sum_s = '0;
    for (int v = 0; v < VOICES; v++) begin
      ph  = phase_q[v] + step_q[v];
      p   = ph[15:8];
      nl  = noise_q[v];
      nxt = chain;
      case (shape_q[v])
        SHAPE_TRI:   wv = p[7] ? 8'(8'd192 - p) : 8'(p - 8'd64);
        SHAPE_PULSE: wv = (p < width_q[v]) ? -8'sd64 : 8'sd63;
        SHAPE_SAW:   wv = 8'({1'b0, p[7:1]} - 8'd64);
        default: begin
          // noise advances only while the phase top byte is above 64
          if (p > 8'd64) begin
            nxt   = lfsr_step(chain);
            chain = nxt;
            nl    = 8'({1'b0, nxt[15:9]} - 8'd64);
            ph    = ph - NoiseDrop;
          end
          wv = nl;
        end
      endcase
      smp_phase[v] = ph;
      smp_noise[v] = nl;
      prod[v]      = wv * $signed({1'b0, amp_q[v][14:8]});
      sum_s        = sum_s + 18'(prod[v]);
    end
    smp_lfsr = chain;
    shifted  = 18'(sum_s >>> 8);
    smp_out  = shifted[7:0] + 8'd128;
  end

  // envelope tick per voice
  always_comb begin : p_env
    env_cfg_t           c;
    logic [16:0]        a_up;
    logic signed [17:0] a_dn;
    logic [14:0]        sus15;
    logic [14:0]        rel15;
    for (int v = 0; v < VOICES; v++) begin
      c            = env_cfg_q[v];
      env_amp[v]   = amp_q[v];
      env_stage[v] = stage_q[v];
      a_up         = {2'b00, amp_q[v]} + {1'b0, c.atk, 8'h00};
      a_dn         = $signed({3'b000, amp_q[v]}) - $signed({2'b00, c.dec, 8'h00});
      sus15        = {c.sus, 8'h00};
      rel15        = {3'b000, c.rel, 4'h0};
      case (stage_q[v])
        ST_ATTACK: begin
          if (a_up >= {2'b00, AmpPeak}) begin
            env_amp[v]   = AmpPeak;
            env_stage[v] = ST_DECAY;
          end else begin
            env_amp[v] = a_up[14:0];
          end
        end
        ST_DECAY: begin
          // floor at sustain, which may also lift a lower level
          env_amp[v] = (a_dn < $signed({3'b000, sus15})) ? sus15 : a_dn[14:0];
        end
        ST_RELEASE: env_amp[v] = (amp_q[v] < rel15) ? '0 : amp_q[v] - rel15;
        default:    env_amp[v] = amp_q[v];
      endcase
    end
  end

  // request decode: next voice state
  always_comb begin
    for (int v = 0; v < VOICES; v++) begin
      phase_d[v] = phase_q[v];
      step_d[v]  = step_q[v];
      shape_d[v] = shape_q[v];
      width_d[v] = width_q[v];
      amp_d[v]   = amp_q[v];
      stage_d[v] = stage_q[v];
      noise_d[v] = noise_q[v];
    end
    lfsr_d = lfsr_q;
    if (s1_adv) begin
      unique case (req_q)
        REQ_SAMPLE: begin
          for (int v = 0; v < VOICES; v++) begin
            phase_d[v] = smp_phase[v];
            noise_d[v] = smp_noise[v];
          end
          lfsr_d = smp_lfsr;
        end
        REQ_ENV_TICK: begin
          for (int v = 0; v < VOICES; v++) begin
            amp_d[v]   = env_amp[v];
            stage_d[v] = env_stage[v];
          end
        end
        REQ_NOTE_ON: begin
          for (int v = 0; v < VOICES; v++) begin
            if (voice_q == 2'(v)) begin
              step_d[v]  = tone_step_q;
              shape_d[v] = shape_e'(wave_shape_q);
              width_d[v] = pulse_width_q;
              stage_d[v] = ST_ATTACK;
            end
          end
        end
        REQ_NOTE_OFF: begin
          for (int v = 0; v < VOICES; v++) begin
            if (voice_q == 2'(v)) stage_d[v] = ST_RELEASE;
          end
        end
        REQ_RESET_ALL: begin
          for (int v = 0; v < VOICES; v++) begin
            phase_d[v] = '0;
            step_d[v]  = '0;
            stage_d[v] = ST_RELEASE;
          end
        end
        default: ;
      endcase
    end
  end

  // pipeline control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    if (in_fire) begin
      req_q         <= req_type_i;
      voice_q       <= voice_i;
      tone_step_q   <= tone_step_i;
      wave_shape_q  <= wave_shape_i;
      pulse_width_q <= pulse_width_i;
    end
  end

  // voice state and envelope registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < VOICES; v++) begin
        env_cfg_q[v] <= '0;
        phase_q[v]   <= '0;
        step_q[v]    <= '0;
        shape_q[v]   <= SHAPE_TRI;
        width_q[v]   <= '0;
        amp_q[v]     <= '0;
        stage_q[v]   <= ST_RELEASE;
        noise_q[v]   <= '0;
      end
      lfsr_q <= LfsrSeed;
    end else begin
      for (int v = 0; v < VOICES; v++) begin
        if (cfg_valid_i && cfg_index_i == CfgIdxW'(v)) begin
          env_cfg_q[v] <= env_cfg_t'(cfg_data_i);
        end
        phase_q[v] <= phase_d[v];
        step_q[v]  <= step_d[v];
        shape_q[v] <= shape_d[v];
        width_q[v] <= width_d[v];
        amp_q[v]   <= amp_d[v];
        stage_q[v] <= stage_d[v];
        noise_q[v] <= noise_d[v];
      end
      lfsr_q <= lfsr_d;
    end
  end

  // checks
  `FVSM_ASSERT(a_ctrl_retires, s1_valid_q && !s1_is_sample |-> s1_adv, "non-sample request stalled")
  `FVSM_ASSERT(a_out_source, $rose(out_valid_q) |-> $past(s1_adv && s1_is_sample), "sample word without a sample tick")
  `FVSM_ASSERT(a_lfsr_live, lfsr_q != 16'h0000, "noise LFSR locked at zero")

endmodule
